/* sv/cocr_pkg.sv */
package cocr_pkg;

   localparam int COORD_BITS      = 10;
   localparam int X_BITS          = COORD_BITS + 1;
   localparam int PIX_BITS        = COORD_BITS + 2;
   localparam int DEC_BITS        = COORD_BITS + 6;
   localparam int COLOR_BITS      = 8;
   localparam int PIXELS_PER_STEP = 8;
   localparam int IDX_BITS        = $clog2(PIXELS_PER_STEP);
   localparam int QUEUE_DEPTH     = 2;
   localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [IDX_BITS-1:0] LAST_PIXEL = IDX_BITS'(PIXELS_PER_STEP - 1);

   localparam logic [COLOR_BITS-1:0] UPPER_COLOR_RESET = 8'd10;
   localparam logic [COLOR_BITS-1:0] LOWER_COLOR_RESET = 8'd5;

   localparam logic signed [DEC_BITS-1:0] BRES_INIT = DEC_BITS'(3);
   localparam logic signed [DEC_BITS-1:0] BRES_NEG  = DEC_BITS'(6);
   localparam logic signed [DEC_BITS-1:0] BRES_POS  = DEC_BITS'(10);
   localparam logic signed [DEC_BITS-1:0] MID_INIT  = DEC_BITS'(1);
   localparam logic signed [DEC_BITS-1:0] MID_NEG   = DEC_BITS'(3);
   localparam logic signed [DEC_BITS-1:0] MID_POS   = DEC_BITS'(5);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DECISION_MODE = 2'd0,
      CSR_UPPER_COLOR   = 2'd1,
      CSR_LOWER_COLOR   = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_START    = 1'b0,
      REQ_CONTINUE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                  decision_mode;
      logic [COLOR_BITS-1:0] upper_color;
      logic [COLOR_BITS-1:0] lower_color;
   } cfg_type;

   typedef struct packed {
      logic                  req_type;
      logic [COORD_BITS-1:0] radius;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
   } req_item_type;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] pixel_x;
      logic signed [PIX_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0]      pixel_color;
      logic                       last_of_step;
      logic                       circle_done;
   } rsp_item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]    center_x;
      logic [COORD_BITS-1:0]    center_y;
      logic signed [X_BITS-1:0] x;
      logic signed [X_BITS-1:0] y;
      logic                     done;
   } step_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/cocr_front.sv */
module cocr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cocr_pkg::req_item_type req_data,
   input  logic                  decision_mode,
   input  cocr_pkg::queue_status_type queue_status,
   output logic                  push,
   output cocr_pkg::step_type    push_data
);

   localparam int DX = cocr_pkg::DEC_BITS - cocr_pkg::X_BITS;
   localparam int DC = cocr_pkg::DEC_BITS - cocr_pkg::COORD_BITS;

   logic signed [cocr_pkg::X_BITS-1:0]   step_x_ff, step_x_in;
   logic signed [cocr_pkg::X_BITS-1:0]   step_y_ff, step_y_in;
   logic signed [cocr_pkg::DEC_BITS-1:0] decision_ff, decision_in;
   logic [cocr_pkg::COORD_BITS-1:0]      center_x_ff, center_x_in;
   logic [cocr_pkg::COORD_BITS-1:0]      center_y_ff, center_y_in;
   logic                                 active_ff, active_in;

   logic                                 accept;
   logic                                 is_start;
   logic signed [cocr_pkg::X_BITS-1:0]   cur_x, cur_y;
   logic signed [cocr_pkg::DEC_BITS-1:0] cur_d, r_ext, x_ext, y_ext, diff, delta;
   logic [cocr_pkg::COORD_BITS-1:0]      cur_h, cur_k;
   logic                                 done;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_data.req_type == cocr_pkg::REQ_START);

   always_comb begin
      r_ext = {{DC{1'b0}}, req_data.radius};
      if (is_start) begin
         cur_x = '0;
         cur_y = {1'b0, req_data.radius};
         cur_h = req_data.center_x;
         cur_k = req_data.center_y;
         cur_d = decision_mode ? cocr_pkg::MID_INIT - r_ext
                               : cocr_pkg::BRES_INIT - (r_ext <<< 1);
      end else begin
         cur_x = step_x_ff;
         cur_y = step_y_ff;
         cur_h = center_x_ff;
         cur_k = center_y_ff;
         cur_d = decision_ff;
      end
      x_ext = {{DX{cur_x[cocr_pkg::X_BITS-1]}}, cur_x};
      y_ext = {{DX{cur_y[cocr_pkg::X_BITS-1]}}, cur_y};
      diff  = x_ext - y_ext;
      if (cur_d[cocr_pkg::DEC_BITS-1]) begin
         delta = decision_mode ? (x_ext <<< 1) + cocr_pkg::MID_NEG
                               : (x_ext <<< 2) + cocr_pkg::BRES_NEG;
         step_y_in = cur_y;
      end else begin
         delta = decision_mode ? (diff <<< 1) + cocr_pkg::MID_POS
                               : (diff <<< 2) + cocr_pkg::BRES_POS;
         step_y_in = cur_y - cocr_pkg::X_BITS'(1);
      end
      decision_in = cur_d + delta;
      step_x_in   = cur_x + cocr_pkg::X_BITS'(1);
      done        = step_x_in > step_y_in;
      center_x_in = cur_h;
      center_y_in = cur_k;
      active_in   = !done;

      push = accept && (is_start || (active_ff && !(step_x_ff > step_y_ff)));

      push_data.center_x = cur_h;
      push_data.center_y = cur_k;
      push_data.x        = cur_x;
      push_data.y        = cur_y;
      push_data.done     = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         active_ff   <= 1'b0;
      end else if (push) begin
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         active_ff   <= active_in;
      end
   end

endmodule

/* sv/cocr_queue.sv */
module cocr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cocr_pkg::step_type         push_data,
   input  logic                       pop,
   output cocr_pkg::step_type         pop_data,
   output cocr_pkg::queue_status_type status
);

   cocr_pkg::step_type                 mem_ff [cocr_pkg::QUEUE_DEPTH];
   logic [cocr_pkg::PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cocr_pkg::PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cocr_pkg::CNT_BITS-1:0]      count_ff, count_in;

   localparam logic [cocr_pkg::PTR_BITS-1:0] PTR_LAST =
      cocr_pkg::PTR_BITS'(cocr_pkg::QUEUE_DEPTH - 1);
   localparam logic [cocr_pkg::CNT_BITS-1:0] CNT_FULL =
      cocr_pkg::CNT_BITS'(cocr_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("step queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("step queue underflow");

endmodule

/* sv/cocr_back.sv */
module cocr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cocr_pkg::queue_status_type queue_status,
   input  cocr_pkg::step_type         pop_data,
   output logic                       pop,
   input  cocr_pkg::cfg_type          cfg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output cocr_pkg::rsp_item_type     rsp_data
);

   localparam int PB = cocr_pkg::PIX_BITS;
   localparam int XE = cocr_pkg::PIX_BITS - cocr_pkg::X_BITS;
   localparam int CE = cocr_pkg::PIX_BITS - cocr_pkg::COORD_BITS;

   cocr_pkg::step_type            cur_ff, cur_in;
   logic                          cur_valid_ff, cur_valid_in;
   logic [cocr_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   cocr_pkg::rsp_item_type        out_ff, out_in;

   logic                          out_free, emit, step_end;
   logic signed [PB-1:0]          h, k, xs, ys;

   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = cur_valid_ff && out_free;
   assign step_end = emit && (idx_ff == cocr_pkg::LAST_PIXEL);
   assign pop      = !queue_status.empty && (!cur_valid_ff || step_end);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      h  = {{CE{1'b0}}, cur_ff.center_x};
      k  = {{CE{1'b0}}, cur_ff.center_y};
      xs = {{XE{cur_ff.x[cocr_pkg::X_BITS-1]}}, cur_ff.x};
      ys = {{XE{cur_ff.y[cocr_pkg::X_BITS-1]}}, cur_ff.y};

      out_in = out_ff;
      out_in.pixel_color  = idx_ff[cocr_pkg::IDX_BITS-1] ? cfg.lower_color : cfg.upper_color;
      out_in.last_of_step = (idx_ff == cocr_pkg::LAST_PIXEL);
      out_in.circle_done  = (idx_ff == cocr_pkg::LAST_PIXEL) && cur_ff.done;
      case (idx_ff)
         3'd0: begin
            out_in.pixel_x = h + xs;
            out_in.pixel_y = k + ys;
         end
         3'd1: begin
            out_in.pixel_x = h + ys;
            out_in.pixel_y = k + xs;
         end
         3'd2: begin
            out_in.pixel_x = h - ys;
            out_in.pixel_y = k + xs;
         end
         3'd3: begin
            out_in.pixel_x = h - xs;
            out_in.pixel_y = k + ys;
         end
         3'd4: begin
            out_in.pixel_x = h - xs;
            out_in.pixel_y = k - ys;
         end
         3'd5: begin
            out_in.pixel_x = h - ys;
            out_in.pixel_y = k - xs;
         end
         3'd6: begin
            out_in.pixel_x = h + ys;
            out_in.pixel_y = k - xs;
         end
         default: begin
            out_in.pixel_x = h + xs;
            out_in.pixel_y = k - ys;
         end
      endcase

      out_valid_in = emit || (out_valid_ff && !rsp_ready);

      cur_in       = pop ? pop_data : cur_ff;
      cur_valid_in = pop || (cur_valid_ff && !step_end);
      if (pop) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_ff <= out_in;
      end
   end

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.circle_done) |-> out_ff.last_of_step)
      else $error("circle_done without last_of_step");

   a_step_holds: assert property (@(posedge clock) disable iff (reset)
      (emit && idx_ff != cocr_pkg::LAST_PIXEL) |=> (cur_valid_ff && idx_ff != '0))
      else $error("step dropped before its eighth pixel");

endmodule

/* sv/circle_octant_rasterizer_core.sv */
// Circle octant rasterizer core.
// req channel: one transaction per step. req_type start loads radius and
//   center and yields the first step; continue yields the next step of the
//   running circle, or nothing once the circle has finished or none runs.
// rsp channel: eight pixel transactions per step, upper_color on the first
//   four and lower_color on the last four; last_of_step marks the eighth,
//   circle_done marks the eighth of the final step.
// csr channel: always ready; index 0 decision mode, 1 upper color,
//   2 lower color; other indexes are dropped. Write only while idle.
// Path: a step goes from the step queue into the pixel stage's step register,
//   and each pixel leaves through the output register. Throughput: one pixel
//   per cycle while rsp_ready is high, set by the single output register. A
//   two-entry step queue lets the request side run ahead of the pixel side.
// Reset: synchronous; clears the queue, the output register and the circle
//   state, and restores the color and mode registers to their defaults.
// Receiver stall: the output register holds its pixel, the pixel stage and
//   then the step queue fill, after which req_ready falls.
module circle_octant_rasterizer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  cocr_pkg::req_item_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output cocr_pkg::rsp_item_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cocr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [cocr_pkg::COLOR_BITS-1:0]        csr_wdata
);

   cocr_pkg::cfg_type          cfg_ff, cfg_in;
   cocr_pkg::queue_status_type queue_status;
   cocr_pkg::step_type         push_data, pop_data;
   logic                       push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (cocr_pkg::csr_index_type'(csr_index))
            cocr_pkg::CSR_DECISION_MODE: cfg_in.decision_mode = csr_wdata[0];
            cocr_pkg::CSR_UPPER_COLOR:   cfg_in.upper_color   = csr_wdata;
            cocr_pkg::CSR_LOWER_COLOR:   cfg_in.lower_color   = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decision_mode <= 1'b0;
         cfg_ff.upper_color   <= cocr_pkg::UPPER_COLOR_RESET;
         cfg_ff.lower_color   <= cocr_pkg::LOWER_COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cocr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .decision_mode (cfg_ff.decision_mode),
      .queue_status  (queue_status),
      .push          (push),
      .push_data     (push_data)
   );

   cocr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   cocr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .cfg          (cfg_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   a_push_needs_request: assert property (@(posedge clock) disable iff (reset)
      push |-> (req_valid && req_ready))
      else $error("step queued without a request transaction");

endmodule

/* verif/tb_circle_octant_rasterizer_core.sv */
`timescale 1ns / 100ps

module tb_circle_octant_rasterizer_core;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 20;
   localparam int N_ROWS      = 23;

   localparam logic [cocr_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      cocr_pkg::req_kind_type kind;
      int                     radius;
      int                     cx;
      int                     cy;
      bit                     typed;
      int                     n_pix;
      int                     at_x;
      int                     at_y;
      bit                     done;
   } stim_row_type;

   // typed rows: with n_pix set, all eight pixels sit on (at_x, at_y); else none
   stim_row_type stim_rows [N_ROWS] = '{
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b1, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,       0,    0,    0, 1'b1, 8,    0,    0, 1'b1},
      '{cocr_pkg::REQ_CONTINUE, 1023, 1023, 1023, 1'b1, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,       0, 1023, 1023, 1'b1, 8, 1023, 1023, 1'b1},
      '{cocr_pkg::REQ_START,    1023,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE, 1023, 1023, 1023, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,    1023, 1023, 1023, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,       1,  100,  200, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,       2, 1023,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,       7,    0, 1023, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_START,     200,  512,  512, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0},
      '{cocr_pkg::REQ_CONTINUE,    0,    0,    0, 1'b0, 0,    0,    0, 1'b0}
   };

   logic                                clock;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   cocr_pkg::req_item_type              req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   cocr_pkg::rsp_item_type              rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [cocr_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [cocr_pkg::COLOR_BITS-1:0]     csr_wdata = '0;

   // mirrored registers and circle state
   logic                                 mode_q  = 1'b0;
   logic [cocr_pkg::COLOR_BITS-1:0]      up_col  = cocr_pkg::UPPER_COLOR_RESET;
   logic [cocr_pkg::COLOR_BITS-1:0]      lo_col  = cocr_pkg::LOWER_COLOR_RESET;
   logic signed [cocr_pkg::X_BITS-1:0]   pos_x   = '0;
   logic signed [cocr_pkg::X_BITS-1:0]   pos_y   = '0;
   logic signed [cocr_pkg::DEC_BITS-1:0] err_term = '0;
   logic [cocr_pkg::COORD_BITS-1:0]      ctr_x   = '0;
   logic [cocr_pkg::COORD_BITS-1:0]      ctr_y   = '0;
   logic                                 circ_active = 1'b0;

   cocr_pkg::rsp_item_type pending_pixels [$];

   int send_idle_pct = 16;
   int stall_pct     = 70;
   int mismatches    = 0;
   int cycle_count   = 0;

   circle_octant_rasterizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_pixel(int px, int py,
                                      logic [cocr_pkg::COLOR_BITS-1:0] color,
                                      logic last, logic done);
      cocr_pkg::rsp_item_type pix;
      pix.pixel_x      = cocr_pkg::PIX_BITS'(px);
      pix.pixel_y      = cocr_pkg::PIX_BITS'(py);
      pix.pixel_color  = color;
      pix.last_of_step = last;
      pix.circle_done  = done;
      pending_pixels.push_back(pix);
   endfunction

   function automatic void plot_step(bit record);
      int   h;
      int   k;
      int   x;
      int   y;
      int   d;
      logic fin;
      h = ctr_x;
      k = ctr_y;
      x = pos_x;
      y = pos_y;
      d = err_term;
      if (d < 0) begin
         d = d + (mode_q ? 2 * x + 3 : 4 * x + 6);
      end else begin
         d = d + (mode_q ? 2 * (x - y) + 5 : 4 * (x - y) + 10);
         pos_y = cocr_pkg::X_BITS'(y - 1);
      end
      err_term = cocr_pkg::DEC_BITS'(d);
      pos_x = cocr_pkg::X_BITS'(x + 1);
      fin = (pos_x > pos_y);
      if (fin) circ_active = 1'b0;
      if (record) begin
         push_pixel(h + x, k + y, up_col, 1'b0, 1'b0);
         push_pixel(h + y, k + x, up_col, 1'b0, 1'b0);
         push_pixel(h - y, k + x, up_col, 1'b0, 1'b0);
         push_pixel(h - x, k + y, up_col, 1'b0, 1'b0);
         push_pixel(h - x, k - y, lo_col, 1'b0, 1'b0);
         push_pixel(h - y, k - x, lo_col, 1'b0, 1'b0);
         push_pixel(h + y, k - x, lo_col, 1'b0, 1'b0);
         push_pixel(h + x, k - y, lo_col, 1'b1, fin);
      end
   endfunction

   function automatic void apply_request(cocr_pkg::req_item_type item, bit record);
      int r;
      if (cocr_pkg::req_kind_type'(item.req_type) == cocr_pkg::REQ_START) begin
         r           = item.radius;
         ctr_x       = item.center_x;
         ctr_y       = item.center_y;
         pos_x       = '0;
         pos_y       = cocr_pkg::X_BITS'(r);
         err_term    = mode_q ? cocr_pkg::DEC_BITS'(1 - r) : cocr_pkg::DEC_BITS'(3 - 2 * r);
         circ_active = 1'b1;
         plot_step(record);
      end else if (circ_active && !(pos_x > pos_y)) begin
         plot_step(record);
      end
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_req(cocr_pkg::req_item_type item, bit record);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(item, record);
   endtask

   task automatic wait_drained(int settle);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [cocr_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [cocr_pkg::COLOR_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         cocr_pkg::CSR_DECISION_MODE: mode_q = val[0];
         cocr_pkg::CSR_UPPER_COLOR:   up_col = val;
         cocr_pkg::CSR_LOWER_COLOR:   lo_col = val;
         default: ;
      endcase
   endtask

   task automatic program_config(logic mode, logic [cocr_pkg::COLOR_BITS-1:0] upper,
                                 logic [cocr_pkg::COLOR_BITS-1:0] lower, bit poke_spare);
      write_csr(cocr_pkg::CSR_DECISION_MODE, {7'($urandom), mode});
      write_csr(cocr_pkg::CSR_UPPER_COLOR, upper);
      write_csr(cocr_pkg::CSR_LOWER_COLOR, lower);
      if (poke_spare) write_csr(CSR_SPARE, 8'hFF);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int n_items, int send_pct, int stall_pct_v);
      cocr_pkg::req_item_type item;
      int                     produced;
      int                     sel;
      produced      = 0;
      send_idle_pct = send_pct;
      stall_pct     = stall_pct_v;
      while (produced < n_items) begin
         item.radius   = cocr_pkg::COORD_BITS'($urandom_range(1023));
         item.center_x = cocr_pkg::COORD_BITS'($urandom_range(1023));
         item.center_y = cocr_pkg::COORD_BITS'($urandom_range(1023));
         if (circ_active && $urandom_range(99) < 96) begin
            item.req_type = cocr_pkg::REQ_CONTINUE;
         end else if (!circ_active && $urandom_range(99) < 15) begin
            item.req_type = cocr_pkg::REQ_CONTINUE;
         end else begin
            item.req_type = cocr_pkg::REQ_START;
            sel = $urandom_range(99);
            if (sel < 60) begin
               item.radius = cocr_pkg::COORD_BITS'($urandom_range(15));
            end else if (sel < 90) begin
               item.radius = cocr_pkg::COORD_BITS'($urandom_range(120, 16));
            end
         end
         if (cocr_pkg::req_kind_type'(item.req_type) == cocr_pkg::REQ_START || circ_active)
            produced++;
         send_req(item, 1'b1);
         if (produced % 50 == 49) wait_drained(0);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL circle_octant_rasterizer_core");
         $finish;
      end
   end

   always @(posedge clock) begin : pixel_check
      cocr_pkg::rsp_item_type exp_pix;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel expected none got %p", $time, rsp_data);
            mismatches++;
         end else begin
            exp_pix = pending_pixels.pop_front();
            check_field("pixel_x", exp_pix.pixel_x, rsp_data.pixel_x);
            check_field("pixel_y", exp_pix.pixel_y, rsp_data.pixel_y);
            check_field("pixel_color", {24'd0, exp_pix.pixel_color},
                        {24'd0, rsp_data.pixel_color});
            check_field("last_of_step", {31'd0, exp_pix.last_of_step},
                        {31'd0, rsp_data.last_of_step});
            check_field("circle_done", {31'd0, exp_pix.circle_done},
                        {31'd0, rsp_data.circle_done});
         end
      end
   end

   initial begin
      cocr_pkg::req_item_type item;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         item.req_type = stim_rows[i].kind;
         item.radius   = cocr_pkg::COORD_BITS'(stim_rows[i].radius);
         item.center_x = cocr_pkg::COORD_BITS'(stim_rows[i].cx);
         item.center_y = cocr_pkg::COORD_BITS'(stim_rows[i].cy);
         send_req(item, !stim_rows[i].typed);
         if (stim_rows[i].typed && stim_rows[i].n_pix != 0) begin
            for (int p = 0; p < cocr_pkg::PIXELS_PER_STEP; p++) begin
               push_pixel(stim_rows[i].at_x, stim_rows[i].at_y, p < 4 ? up_col : lo_col,
                          p == cocr_pkg::PIXELS_PER_STEP - 1,
                          p == cocr_pkg::PIXELS_PER_STEP - 1 && stim_rows[i].done);
            end
         end
      end

      // switch mode while the last directed circle is still running
      wait_drained(SETTLE);
      program_config(1'b1, 8'hFF, 8'h00, 1'b1);
      run_random(140, 16, 70);

      wait_drained(SETTLE);
      program_config(1'b0, 8'h00, 8'hFF, 1'b0);
      run_random(140, 70, 16);

      wait_drained(SETTLE);
      program_config(1'($urandom_range(1)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'b0);
      run_random(130, 0, 0);

      wait_drained(SETTLE);
      if (mismatches == 0) begin
         $display("PASS circle_octant_rasterizer_core");
      end else begin
         $display("FAIL circle_octant_rasterizer_core");
      end
      $finish;
   end

endmodule
